// ===== hdl/bub_pkg.sv =====
// shared types and constants of the button and uart bus bridge
package bub_pkg;

    // operation codes carried by an input word
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_WR_START   = 3'd1,
        OP_WR_BYTE    = 3'd2,
        OP_RD_START   = 3'd3,
        OP_RD_BYTE    = 3'd4,
        OP_UART_RX    = 3'd5
    } op_t;

    localparam int unsigned SW_W   = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LED_W  = 4;

    // command byte decoding
    localparam logic [BYTE_W-1:0] CMD_NIBBLE_MASK = 8'hF0;
    localparam int unsigned       CMD_TX_BIT      = 7;
    localparam int unsigned       CMD_RDSEL_BIT   = 6;
    localparam int unsigned       CMD_RDMODE_BIT  = 0;

    // upper leds are active low, reset turns them off
    localparam logic [LED_W-2:0] LED_UPPER_RESET = '1;

endpackage

// ===== hdl/button_uart_bus_bridge.sv =====
// button debounce and uart fifo bus bridge, top level
//
// Bus-slave bridge for four switches, four LEDs and a UART. Each input word
// carries one operation (timer tick with switch sample, write start, write
// byte, read start, read byte, or a byte received by the UART) and yields
// exactly one result word with read data, LED levels, the UART transmit byte
// and the interrupt line. Words pass through an input register, one level of
// logic that updates the bridge state, and a result register, so one word is
// taken every clock cycle unless the receiver stalls; each result is held in
// the result register. The receive FIFO is an internal memory of FIFO_DEPTH
// bytes whose head entry is kept in a read register, so a pop never stalls.
// A full FIFO drops incoming bytes and a pop from an empty FIFO returns 0.
module button_uart_bus_bridge
    import bub_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_operation,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [SW_W-1:0]   s_switch_sample,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_read_data,
    output logic              m_more_data,
    output logic [LED_W-1:0]  m_led_levels,
    output logic              m_uart_tx_valid,
    output logic [BYTE_W-1:0] m_uart_tx_byte,
    output logic              m_irq_line
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // input register
    logic              in_valid_reg;
    op_t               op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [SW_W-1:0]   sw_reg;

    // bridge state
    logic [SW_W-1:0]   deb_reg, deb_next;
    logic [SW_W-1:0]   cnt_lo_reg, cnt_lo_next;
    logic [SW_W-1:0]   cnt_hi_reg, cnt_hi_next;
    logic [SW_W-1:0]   last_rd_reg, last_rd_next;
    logic              wr_uart_reg, wr_uart_next;
    logic              rd_uart_reg, rd_uart_next;
    logic              len_pend_reg, len_pend_next;
    logic [LED_W-2:0]  led_up_reg, led_up_next;
    logic              irq_reg, irq_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // fifo storage and head read register
    logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] head_data_reg;
    logic              fifo_we;

    // result register
    logic              m_valid_reg;
    logic [BYTE_W-1:0] rd_data_reg, rd_data_next;
    logic              more_reg, more_next;
    logic [LED_W-1:0]  led_reg, led_next;
    logic              tx_valid_reg, tx_valid_next;
    logic [BYTE_W-1:0] tx_byte_reg, tx_byte_next;
    logic              irq_out_reg;

    logic              advance;

    // handshake: the word in the input register moves on when the result slot frees
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_operation);
            data_reg <= s_data_byte;
            sw_reg   <= s_switch_sample;
        end
    end

    // per-word state update and result
    always_comb begin
        logic [SW_W-1:0] delta;
        logic [SW_W-1:0] changed;
        logic [SW_W-1:0] rise;
        logic [SW_W-1:0] fall;

        deb_next      = deb_reg;
        cnt_lo_next   = cnt_lo_reg;
        cnt_hi_next   = cnt_hi_reg;
        last_rd_next  = last_rd_reg;
        wr_uart_next  = wr_uart_reg;
        rd_uart_next  = rd_uart_reg;
        len_pend_next = len_pend_reg;
        led_up_next   = led_up_reg;
        irq_next      = irq_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        fifo_we       = 1'b0;
        rd_data_next  = '0;
        more_next     = 1'b0;
        tx_valid_next = 1'b0;
        tx_byte_next  = '0;

        // two-bit vertical counters per switch
        delta   = sw_reg ^ deb_reg;
        changed = '0;
        rise    = deb_reg & ~last_rd_reg;
        fall    = ~deb_reg & last_rd_reg;

        if (advance) begin
            unique case (op_reg)
                OP_TICK: begin
                    cnt_hi_next = (cnt_hi_reg ^ cnt_lo_reg) & delta;
                    cnt_lo_next = ~cnt_lo_reg & delta;
                    changed     = delta & ~(cnt_lo_next | cnt_hi_next);
                    deb_next    = deb_reg ^ changed;
                    if (changed != '0) begin
                        irq_next = 1'b1;
                    end
                end
                OP_WR_START: begin
                    wr_uart_next = 1'b0;
                end
                OP_WR_BYTE: begin
                    if (wr_uart_reg) begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = data_reg;
                    end else if ((data_reg & CMD_NIBBLE_MASK) == '0) begin
                        led_up_next = data_reg[LED_W-1:1];
                    end else begin
                        if (data_reg[CMD_TX_BIT]) begin
                            wr_uart_next = 1'b1;
                        end
                        if (data_reg[CMD_RDSEL_BIT]) begin
                            rd_uart_next = data_reg[CMD_RDMODE_BIT];
                        end
                    end
                end
                OP_RD_START: begin
                    if (rd_uart_reg) begin
                        len_pend_next = 1'b1;
                    end
                end
                OP_RD_BYTE: begin
                    priority if (!rd_uart_reg) begin
                        // edge flags since the last button read
                        rd_data_next = {fall, rise};
                        last_rd_next = deb_reg;
                        irq_next     = 1'b0;
                    end else if (len_pend_reg) begin
                        rd_data_next  = BYTE_W'(count_reg);
                        more_next     = (count_reg != '0);
                        len_pend_next = 1'b0;
                    end else if (count_reg != '0) begin
                        rd_data_next = head_data_reg;
                        head_next    = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        count_next   = count_reg - 1'b1;
                        more_next    = (count_next != '0);
                    end else begin
                        rd_data_next = '0;
                        more_next    = 1'b0;
                    end
                end
                OP_UART_RX: begin
                    if (count_reg < CNT_FULL) begin
                        fifo_we    = 1'b1;
                        tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        led_next = {led_up_next, (count_next == '0)};
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg      <= '0;
            cnt_lo_reg   <= '0;
            cnt_hi_reg   <= '0;
            last_rd_reg  <= '0;
            wr_uart_reg  <= 1'b0;
            rd_uart_reg  <= 1'b0;
            len_pend_reg <= 1'b0;
            led_up_reg   <= LED_UPPER_RESET;
            irq_reg      <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end else begin
            deb_reg      <= deb_next;
            cnt_lo_reg   <= cnt_lo_next;
            cnt_hi_reg   <= cnt_hi_next;
            last_rd_reg  <= last_rd_next;
            wr_uart_reg  <= wr_uart_next;
            rd_uart_reg  <= rd_uart_next;
            len_pend_reg <= len_pend_next;
            led_up_reg   <= led_up_next;
            irq_reg      <= irq_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // fifo memory write
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[tail_reg] <= data_reg;
        end
    end

    // head entry read, with bypass when the head slot is written this cycle
    always_ff @(posedge aclk) begin
        if (fifo_we && (tail_reg == head_next)) begin
            head_data_reg <= data_reg;
        end else begin
            head_data_reg <= fifo_mem[head_next];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_data_reg  <= rd_data_next;
            more_reg     <= more_next;
            led_reg      <= led_next;
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            irq_out_reg  <= irq_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = rd_data_reg;
    assign m_more_data     = more_reg;
    assign m_led_levels    = led_reg;
    assign m_uart_tx_valid = tx_valid_reg;
    assign m_uart_tx_byte  = tx_byte_reg;
    assign m_irq_line      = irq_out_reg;

endmodule

// ===== dv/tb_button_uart_bus_bridge.sv =====
// testbench for the button debounce and uart fifo bus bridge
`timescale 1ns / 1ps

module tb_button_uart_bus_bridge;
    import bub_pkg::*;

    localparam int unsigned FIFO_DEPTH = 32;

    // operation codes the block does not define
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // command bytes used by the directed part
    localparam logic [BYTE_W-1:0] CMD_RD_UART   = 8'h41;
    localparam logic [BYTE_W-1:0] CMD_RD_BUTTON = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_TX_ENABLE = 8'h80;

    localparam int unsigned RANDOM_WORDS = 1400;

    typedef struct {
        logic [2:0]        op;
        logic [BYTE_W-1:0] data;
        logic [SW_W-1:0]   sw;
        int unsigned       gap;
        bit                drain;
    } bus_word_t;

    typedef struct {
        logic [BYTE_W-1:0] rd_data;
        logic              more;
        logic [LED_W-1:0]  leds;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq;
    } bridge_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_operation = OP_TICK;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic [SW_W-1:0]   s_switch_sample = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_read_data;
    logic              m_more_data;
    logic [LED_W-1:0]  m_led_levels;
    logic              m_uart_tx_valid;
    logic [BYTE_W-1:0] m_uart_tx_byte;
    logic              m_irq_line;

    button_uart_bus_bridge #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_byte    (s_data_byte),
        .s_switch_sample(s_switch_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_more_data    (m_more_data),
        .m_led_levels   (m_led_levels),
        .m_uart_tx_valid(m_uart_tx_valid),
        .m_uart_tx_byte (m_uart_tx_byte),
        .m_irq_line     (m_irq_line)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bus_word_t      word_q[$];
    bridge_result_t expect_q[$];
    int unsigned    errors = 0;
    int unsigned    n_predicted = 0;
    int unsigned    n_seen = 0;

    // shadow of the bridge state
    logic [SW_W-1:0]    sh_debounced;
    logic [SW_W-1:0]    sh_cnt_lo;
    logic [SW_W-1:0]    sh_cnt_hi;
    logic [SW_W-1:0]    sh_last_read;
    logic               sh_tx_mode;
    logic               sh_uart_read;
    logic               sh_len_pending;
    logic [LED_W-2:0]   sh_led_upper;
    logic               sh_irq;
    logic [BYTE_W-1:0]  sh_fifo[FIFO_DEPTH];
    int unsigned        sh_head;
    int unsigned        sh_tail;
    int unsigned        sh_count;

    task automatic bridge_clear();
        sh_debounced   = '0;
        sh_cnt_lo      = '0;
        sh_cnt_hi      = '0;
        sh_last_read   = '0;
        sh_tx_mode     = 1'b0;
        sh_uart_read   = 1'b0;
        sh_len_pending = 1'b0;
        sh_led_upper   = LED_UPPER_RESET;
        sh_irq         = 1'b0;
        sh_head        = 0;
        sh_tail        = 0;
        sh_count       = 0;
    endtask

    // advance the shadow state by one word and return the result it yields
    function automatic bridge_result_t bridge_step(bus_word_t w);
        bridge_result_t   r;
        logic [SW_W-1:0]  delta;
        logic [SW_W-1:0]  changed;
        logic [SW_W-1:0]  rise;
        logic [SW_W-1:0]  fall;
        r = '{rd_data: '0, more: 1'b0, leds: '0, tx_valid: 1'b0, tx_byte: '0, irq: 1'b0};
        case (w.op)
            OP_TICK: begin
                // two-bit vertical counter per switch
                delta     = w.sw ^ sh_debounced;
                sh_cnt_hi = (sh_cnt_hi ^ sh_cnt_lo) & delta;
                sh_cnt_lo = ~sh_cnt_lo & delta;
                changed   = delta & ~(sh_cnt_lo | sh_cnt_hi);
                sh_debounced = sh_debounced ^ changed;
                if (changed != '0) sh_irq = 1'b1;
            end
            OP_WR_START: sh_tx_mode = 1'b0;
            OP_WR_BYTE: begin
                if (sh_tx_mode) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = w.data;
                end else if ((w.data & CMD_NIBBLE_MASK) == '0) begin
                    sh_led_upper = w.data[LED_W-1:1];
                end else begin
                    if (w.data[CMD_TX_BIT]) sh_tx_mode = 1'b1;
                    if (w.data[CMD_RDSEL_BIT]) sh_uart_read = w.data[CMD_RDMODE_BIT];
                end
            end
            OP_RD_START: if (sh_uart_read) sh_len_pending = 1'b1;
            OP_RD_BYTE: begin
                if (!sh_uart_read) begin
                    // edge flags since the last button read
                    rise = sh_debounced & ~sh_last_read;
                    fall = ~sh_debounced & sh_last_read;
                    sh_last_read = sh_debounced;
                    r.rd_data = {fall, rise};
                    sh_irq = 1'b0;
                end else if (sh_len_pending) begin
                    r.rd_data = BYTE_W'(sh_count);
                    r.more = (sh_count > 0);
                    sh_len_pending = 1'b0;
                end else begin
                    if (sh_count > 0) begin
                        r.rd_data = sh_fifo[sh_head];
                        sh_head = (sh_head + 1 >= FIFO_DEPTH) ? 0 : sh_head + 1;
                        sh_count--;
                    end
                    r.more = (sh_count > 0);
                end
            end
            OP_UART_RX: begin
                // a full fifo drops the byte
                if (sh_count < FIFO_DEPTH) begin
                    sh_fifo[sh_tail] = w.data;
                    sh_tail = (sh_tail + 1 >= FIFO_DEPTH) ? 0 : sh_tail + 1;
                    sh_count++;
                end
            end
            default: ;
        endcase
        r.leds = {sh_led_upper, sh_count == 0};
        r.irq  = sh_irq;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    bit quiet_seq = 1'b0;
    bit pending_drain = 1'b0;

    task automatic add_word(logic [2:0] op, logic [BYTE_W-1:0] data, logic [SW_W-1:0] sw);
        bus_word_t w;
        w.op    = op;
        w.data  = data;
        w.sw    = sw;
        w.gap   = quiet_seq ? 0 : pick_gap();
        w.drain = pending_drain;
        pending_drain = 1'b0;
        word_q.push_back(w);
    endtask

    // random command byte for a write transaction
    function automatic logic [BYTE_W-1:0] pick_command();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        case ($urandom_range(0, 3))
            0: b = b & ~CMD_NIBBLE_MASK;
            1: begin
                b[CMD_RDSEL_BIT] = 1'b1;
                b[CMD_TX_BIT]    = 1'b0;
            end
            2: b[CMD_TX_BIT] = 1'b1;
            default: ;
        endcase
        return b;
    endfunction

    // word driver
    int unsigned gap_left = 0;
    bus_word_t   cur_word;

    always @(posedge aclk) begin : drive_words
        bit hold;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            hold = 1'b0;
            if (s_valid && s_ready) begin
                expect_q.push_back(bridge_step(cur_word));
                n_predicted++;
                gap_left = cur_word.gap;
            end else if (s_valid) begin
                hold = 1'b1;
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (word_q.size() != 0 &&
                             !(word_q[0].drain && n_predicted != n_seen)) begin
                    cur_word = word_q.pop_front();
                    s_valid         <= 1'b1;
                    s_operation     <= cur_word.op;
                    s_data_byte     <= cur_word.data;
                    s_switch_sample <= cur_word.sw;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // result monitor and receiver stalls
    int unsigned    stall_left = 0;
    logic [15:0]    cyc = '0;

    always @(posedge aclk) begin : watch_results
        bridge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_seen <= n_seen + 1;
            if (expect_q.size() == 0) begin
                errors++;
                $error("result word with nothing expected");
            end else begin
                want = expect_q.pop_front();
                check_field("read_data", want.rd_data, m_read_data);
                check_field("more_data", BYTE_W'(want.more), BYTE_W'(m_more_data));
                check_field("led_levels", BYTE_W'(want.leds), BYTE_W'(m_led_levels));
                check_field("uart_tx_valid", BYTE_W'(want.tx_valid),
                            BYTE_W'(m_uart_tx_valid));
                check_field("uart_tx_byte", want.tx_byte, m_uart_tx_byte);
                check_field("irq_line", BYTE_W'(want.irq), BYTE_W'(m_irq_line));
            end
        end
        // quarter of the time the receiver never stalls
        cyc++;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (cyc[9:8] != 2'd0) stall_left = pick_gap();
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned n;
        int unsigned r;
        logic [SW_W-1:0] target;
        bridge_clear();

        // directed: spare codes, leds, fifo, read modes, debounce, tx forwarding
        add_word(OP_SPARE_LO, 8'hFF, 4'hF);
        add_word(OP_SPARE_HI, 8'h00, 4'h0);
        add_word(OP_WR_START, 8'h00, 4'h0);
        add_word(OP_WR_BYTE, 8'h00, 4'h0);
        add_word(OP_UART_RX, 8'hFF, 4'h0);
        add_word(OP_UART_RX, 8'h00, 4'h0);
        add_word(OP_WR_BYTE, CMD_RD_UART, 4'h0);
        add_word(OP_RD_START, 8'h00, 4'h0);
        add_word(OP_RD_START, 8'h00, 4'h0);
        repeat (4) add_word(OP_RD_BYTE, 8'h00, 4'h0);
        add_word(OP_WR_BYTE, CMD_RD_BUTTON, 4'h0);
        add_word(OP_RD_START, 8'h00, 4'h0);
        repeat (4) add_word(OP_TICK, 8'h00, 4'hF);
        add_word(OP_TICK, 8'h00, 4'h0);
        add_word(OP_RD_BYTE, 8'h00, 4'h0);
        add_word(OP_WR_BYTE, CMD_TX_ENABLE, 4'h0);
        pending_drain = 1'b1;
        add_word(OP_WR_BYTE, 8'hAA, 4'h5);
        add_word(OP_WR_START, 8'h55, 4'hA);
        add_word(OP_WR_BYTE, 8'h0E, 4'h0);

        // random transactions
        n = word_q.size() + RANDOM_WORDS;
        while (word_q.size() < n) begin
            quiet_seq = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 25) begin
                // tick run, mostly stable switches with some bounce
                target = SW_W'($urandom);
                repeat ($urandom_range(1, 7)) begin
                    if ($urandom_range(0, 99) < 15)
                        add_word(OP_TICK, BYTE_W'($urandom), SW_W'($urandom));
                    else
                        add_word(OP_TICK, BYTE_W'($urandom), target);
                end
            end else if (r < 45) begin
                add_word(OP_WR_START, BYTE_W'($urandom), SW_W'($urandom));
                repeat ($urandom_range(1, 5))
                    add_word(OP_WR_BYTE, pick_command(), SW_W'($urandom));
            end else if (r < 65) begin
                if ($urandom_range(0, 9) != 0)
                    add_word(OP_RD_START, BYTE_W'($urandom), SW_W'($urandom));
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 36)
                                                    : $urandom_range(1, 6))
                    add_word(OP_RD_BYTE, BYTE_W'($urandom), SW_W'($urandom));
            end else if (r < 85) begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 6))
                    add_word(OP_UART_RX, BYTE_W'($urandom), SW_W'($urandom));
            end else if (r < 95) begin
                repeat ($urandom_range(1, 4))
                    add_word(3'($urandom), BYTE_W'($urandom), SW_W'($urandom));
            end else begin
                pending_drain = 1'b1;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0 || s_valid || expect_q.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (expect_q.size() != 0) begin
            errors++;
            $error("%0d result words never arrived", expect_q.size());
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
